// File: src/rcrt_pkg.sv
`default_nettype none

package rcrt_pkg;

   localparam int ADDR_W = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int COUNT_W = 4;

   // command codes
   localparam logic CMD_CLAIM = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // status codes
   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_BASE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_LIMIT = 2'd1;

   // argument and return counts that each command needs
   localparam logic [COUNT_W-1:0] CLAIM_ARGS = 4'd3;
   localparam logic [COUNT_W-1:0] CLAIM_RETS = 4'd1;
   localparam logic [COUNT_W-1:0] RELEASE_ARGS = 4'd2;
   localparam logic [COUNT_W-1:0] RELEASE_RETS = 4'd0;

   typedef struct packed {
      logic               cmd;
      logic [COUNT_W-1:0] arg_count;
      logic [COUNT_W-1:0] ret_count;
      logic [ADDR_W-1:0]  region_start;
      logic [ADDR_W-1:0]  region_size;
      logic [ADDR_W-1:0]  align_req;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [ADDR_W-1:0] base_addr;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start_addr;
      logic [ADDR_W-1:0] end_addr;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_COMMIT
   } state_type;

endpackage

`default_nettype wire

// File: src/rcrt_ram.sv
`default_nettype none

module rcrt_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: src/region_claim_release_table_core.sv
`default_nettype none

// region claim/release table
//
// keeps ENTRIES address regions (start, exclusive end) in one synchronous ram;
// an entry with end zero is free
// request channel: a transaction is taken at a rising edge with start high and
// busy low; cmd selects claim or release, the other fields are its arguments
// response channel: rsp_valid is high for exactly one cycle with rsp; the
// receiver cannot stall, every response must be taken in that cycle
// config channel: csr_valid/csr_ready write image_base (index 0) or
// image_limit (index 1); csr_ready is always high, write only while idle
// a request rejected by the count, alignment or image checks is answered from
// the check state; any other request scans every entry, one ram read per
// cycle, and is answered from the commit state; no new request is taken
// until the response shows
// the scan length is set by the single ram read port
// reset: synchronous, clears the config and control registers and then sweeps
// the ram to zero, one entry per cycle, with busy high
// a new request may be taken in the cycle its predecessor's response shows

module region_claim_release_table_core #(
   parameter int ENTRIES = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire rcrt_pkg::req_type                   req,
   output logic                                     rsp_valid,
   output rcrt_pkg::rsp_type                        rsp,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rcrt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [rcrt_pkg::ADDR_W-1:0]         csr_wdata
);

   import rcrt_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int ENTRY_W = $bits(entry_type);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);

   // fsm and sweep counter
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // latched request and its wrapped end
   req_type           req_ff, req_in;
   logic [ADDR_W-1:0] end_ff, end_in;

   // config registers
   logic [ADDR_W-1:0] image_base_ff, image_base_in;
   logic [ADDR_W-1:0] image_limit_ff, image_limit_in;

   // read pipeline: entry index whose data arrives this cycle
   logic             chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;

   // scan results
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // ram ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type        rd_entry;

   logic accept;
   logic counts_ok;
   logic pre_ok;
   logic in_image;
   logic overlap;
   logic match;

   rcrt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry = entry_type'(rd_data);
   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   // image, count and alignment checks on the latched request
   assign in_image = (req_ff.region_start >= image_base_ff) && (end_ff < image_limit_ff);
   assign counts_ok = (req_ff.cmd == CMD_CLAIM)
      ? (req_ff.arg_count == CLAIM_ARGS) && (req_ff.ret_count == CLAIM_RETS)
      : (req_ff.arg_count == RELEASE_ARGS) && (req_ff.ret_count == RELEASE_RETS);
   assign pre_ok = counts_ok && !in_image
      && ((req_ff.cmd == CMD_RELEASE) || (req_ff.align_req == '0));

   // per-entry tests on the word read last cycle
   assign overlap =
      ((req_ff.region_start >= rd_entry.start_addr) &&
       (req_ff.region_start < rd_entry.end_addr)) ||
      ((end_ff >= rd_entry.start_addr) && (end_ff < rd_entry.end_addr));
   assign match = (rd_entry.start_addr == req_ff.region_start) &&
                  (rd_entry.end_addr == end_ff);

   // config writes
   always_comb begin
      image_base_in = image_base_ff;
      image_limit_in = image_limit_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_IMAGE_BASE) begin
            image_base_in = csr_wdata;
         end
         if (csr_index == CSR_IMAGE_LIMIT) begin
            image_limit_in = csr_wdata;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == LAST_CNT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = pre_ok ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (chk_valid_ff && (chk_idx_ff == LAST_IDX)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      cnt_in = cnt_ff;
      req_in = req_ff;
      end_in = end_ff;
      chk_valid_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in = free_idx_ff;
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      wr_en = 1'b0;
      wr_addr = cnt_ff[IDX_W-1:0];
      wr_entry = '0;
      rd_en = 1'b0;
      rd_addr = cnt_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            // zero sweep after reset
            wr_en = 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               req_in = req;
               end_in = req.region_start + req.region_size;
            end
         end
         ST_CHECK: begin
            cnt_in = '0;
            free_found_in = 1'b0;
            free_idx_in = '0;
            hit_in = 1'b0;
            hit_idx_in = '0;
            if (!pre_ok) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = STATUS_FAIL;
               rsp_in.base_addr = '0;
            end
         end
         ST_SCAN: begin
            // issue one read per cycle
            if (cnt_ff < ENTRIES_CNT) begin
               rd_en = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in = cnt_ff[IDX_W-1:0];
            end
            // evaluate the word that came back
            if (chk_valid_ff) begin
               if (req_ff.cmd == CMD_CLAIM) begin
                  if (rd_entry.end_addr == '0) begin
                     if (!free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in = chk_idx_ff;
                     end
                  end else if (overlap) begin
                     hit_in = 1'b1;
                  end
               end else if (match && !hit_ff) begin
                  // free entries count too, first match wins
                  hit_in = 1'b1;
                  hit_idx_in = chk_idx_ff;
               end
            end
         end
         ST_COMMIT: begin
            rsp_valid_in = 1'b1;
            rsp_in.base_addr = '0;
            if (req_ff.cmd == CMD_CLAIM) begin
               if (!hit_ff && free_found_ff) begin
                  // a wrapped end of zero is stored and leaves the slot free
                  wr_en = 1'b1;
                  wr_addr = free_idx_ff;
                  wr_entry.start_addr = req_ff.region_start;
                  wr_entry.end_addr = end_ff;
                  rsp_in.status = STATUS_OK;
                  rsp_in.base_addr = req_ff.region_start;
               end else begin
                  rsp_in.status = STATUS_FAIL;
               end
            end else begin
               if (hit_ff) begin
                  wr_en = 1'b1;
                  wr_addr = hit_idx_ff;
                  rsp_in.status = STATUS_OK;
               end else begin
                  rsp_in.status = STATUS_FAIL;
               end
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         image_base_ff <= '0;
         image_limit_ff <= '0;
         free_found_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         image_base_ff <= image_base_in;
         image_limit_ff <= image_limit_in;
         free_found_ff <= free_found_in;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      end_ff <= end_in;
      chk_idx_ff <= chk_idx_in;
      free_idx_ff <= free_idx_in;
      hit_idx_ff <= hit_idx_in;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   // a response strobe never comes back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe held for two cycles");

   // an accepted transaction makes the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after accepting a transaction");

   // failures and releases report a zero base
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_ff.status == STATUS_FAIL) || (req_ff.cmd == CMD_RELEASE)))
         |-> (rsp_ff.base_addr == '0))
      else $error("nonzero base on failure or release");

   // no table write while the scan is reading
   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !wr_en)
      else $error("table written during scan");

   // the response comes only as the block returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("response outside idle");
`endif

endmodule

`default_nettype wire
